// ===== rtl/fpba_pkg.sv =====
// Package for the fit policy block allocator.
// Holds the sequencer state type, the policy codes and the register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Placement policy codes.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NONE  = 2'd3;

   // Request kinds.
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_ALLOC   = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FIT_MODE    = 2'd0;
   localparam logic [1:0] CSR_BLOCK_COUNT = 2'd1;

   // Widths fixed by the interface.
   localparam int CSR_DATA_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;

endpackage

`default_nettype wire

// ===== rtl/fpba_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the free size table of the allocator. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fit_policy_block_allocator_unit.sv =====
// Top level of the fit policy block allocator: sequencer, scan compare unit,
// write-back and result register. Depends on fpba_pkg and fpba_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake           Payload
// req_       in         req_valid/stall     kind, block_index, size_value
// rsp_       out        rsp_valid/stall     granted, chosen_block, remaining_after
// csr_       in         csr_write_en        csr_index, csr_write_data
//
// A load request writes the table in the cycle in which it is accepted.
// An allocation request over n = min(block_count, NUM_BLOCKS) blocks, n > 0, passes through n
// reads of the table's read port, a drain step for the last read data, a step to close the
// scan and one write-back step; with no block to scan, only the close and write-back steps.
// Reset clears the sequencer and the result valid flag; the table is not cleared.
// req_stall is high while a request is in work; a request behind a waiting result holds in
// its write-back step until that result is taken.

module fit_policy_block_allocator_unit #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [3:0]  req_block_index,
   input  wire logic [15:0] req_size_value,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_granted,
   output logic [3:0]       rsp_chosen_block,
   output logic [15:0]      rsp_remaining_after,
   // Configuration port.
   input  wire logic                                  csr_write_en,
   input  wire logic [fpba_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [fpba_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_BITS = (CNT_BITS > 5) ? CNT_BITS : 5;

   // Configuration registers.
   logic [1:0] fit_mode_ff;
   logic [4:0] block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= fpba_pkg::FIT_FIRST;
         block_count_ff <= 5'd16;
      end else if (csr_write_en) begin
         case (csr_index)
            fpba_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_write_data[1:0];
            fpba_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // Sequencer and scan state.
   fpba_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic [CNT_BITS-1:0]  addr_cnt_ff, addr_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_room_ff, best_room_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [3:0]           rsp_chosen_ff, rsp_chosen_in;
   logic [15:0]          rsp_remain_ff, rsp_remain_in;

   // RAM ports.
   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [SIZE_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_BITS-1:0]  ram_rd_addr;
   logic [SIZE_BITS-1:0] ram_rd_data;

   logic                 req_accept;
   logic                 rsp_free;
   logic [CMP_BITS-1:0]  count_wide;
   logic [CNT_BITS-1:0]  count_clip;
   logic                 room_fits;
   logic                 room_better;
   logic [SIZE_BITS-1:0] remain;

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != fpba_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Block count clipped to the table depth.
   assign count_wide = CMP_BITS'(block_count_ff);
   assign count_clip = (count_wide > CMP_BITS'(NUM_BLOCKS)) ?
                       CNT_BITS'(NUM_BLOCKS) : CNT_BITS'(block_count_ff);

   // Shared compare unit: does the entry fit, and does it beat the current pick.
   assign room_fits   = (ram_rd_data >= size_ff);
   assign room_better = !found_ff ||
                        ((fit_mode_ff == fpba_pkg::FIT_BEST)  && (ram_rd_data < best_room_ff)) ||
                        ((fit_mode_ff == fpba_pkg::FIT_WORST) && (ram_rd_data > best_room_ff));

   // Subtractor for the write-back.
   assign remain = best_room_ff - size_ff;

   // Next-state logic.
   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      addr_cnt_in    = addr_cnt_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = rd_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_room_in   = best_room_ff;
      size_in        = size_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_remain_in  = rsp_remain_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = IDX_BITS'(req_block_index);
      ram_wr_data    = SIZE_BITS'(req_size_value);
      ram_rd_en      = 1'b0;
      ram_rd_addr    = addr_cnt_ff[IDX_BITS-1:0];

      case (state_ff)
         fpba_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == fpba_pkg::KIND_LOAD) begin
                  // Loads beyond the table are dropped.
                  ram_wr_en = ({28'd0, req_block_index} < 32'(NUM_BLOCKS));
               end else begin
                  size_in     = SIZE_BITS'(req_size_value);
                  limit_in    = (fit_mode_ff == fpba_pkg::FIT_NONE) ? '0 : count_clip;
                  addr_cnt_in = '0;
                  found_in    = 1'b0;
                  pick_in     = '0;
                  state_in    = fpba_pkg::ST_SCAN;
               end
            end
         end

         fpba_pkg::ST_SCAN: begin
            // Issue the next read while judging the entry read last cycle.
            if (addr_cnt_ff < limit_ff) begin
               ram_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               rd_idx_in   = addr_cnt_ff[IDX_BITS-1:0];
               addr_cnt_in = addr_cnt_ff + 1'b1;
            end
            if (rd_pend_ff && room_fits && room_better) begin
               found_in     = 1'b1;
               pick_in      = rd_idx_ff;
               best_room_in = ram_rd_data;
            end
            if ((addr_cnt_ff == limit_ff) && !rd_pend_ff) begin
               state_in = fpba_pkg::ST_FINISH;
            end
         end

         fpba_pkg::ST_FINISH: begin
            // Write back the chosen block and hand the result over.
            ram_wr_en   = found_ff;
            ram_wr_addr = pick_ff;
            ram_wr_data = remain;
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_chosen_in  = found_ff ? 4'(pick_ff) : 4'd0;
               rsp_remain_in  = found_ff ? 16'(remain) : 16'd0;
               state_in       = fpba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fpba_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpba_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         addr_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         addr_cnt_ff  <= addr_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      pick_ff        <= pick_in;
      best_room_ff   <= best_room_in;
      size_ff        <= size_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_remain_ff  <= rsp_remain_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_granted_ff;
   assign rsp_chosen_block    = rsp_chosen_ff;
   assign rsp_remaining_after = rsp_remain_ff;

   // A new result is only loaded at the end of a request.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fpba_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   // A refused request reports zeros.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |-> (rsp_chosen_ff == 4'd0 && rsp_remain_ff == 16'd0))
      else $error("refused request with nonzero payload");

   // The scan never runs past the blocks in use.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpba_pkg::ST_SCAN) |-> (addr_cnt_ff <= limit_ff))
      else $error("scan address beyond the block count");

   // A picked block always lies inside the scanned range.
   a_pick_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != fpba_pkg::ST_IDLE) && found_ff) |-> (CNT_BITS'(pick_ff) < limit_ff))
      else $error("picked block outside the blocks in use");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for fit_policy_block_allocator_unit, all placement policies.
// It drives random loads and allocation requests and predicts every result in step.
// Depends on fpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_BLOCKS      = 16;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES   = 24;
   localparam int LONG_HOLD       = 300;
   localparam int STUCK_LIMIT     = 3000;

   // One request as it goes over the wire, and one expected result.
   typedef struct packed {
      logic        kind;
      logic [3:0]  blk;
      logic [15:0] amount;
   } alloc_req_type;

   typedef struct packed {
      logic        granted;
      logic [3:0]  blk;
      logic [15:0] remain;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [3:0]  req_block_index = '0;
   logic [15:0] req_size_value = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [3:0]  rsp_chosen_block;
   logic [15:0] rsp_remaining_after;

   logic                                csr_write_en = 1'b0;
   logic [fpba_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fpba_pkg::CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // Shadow copy of the free-size table and the configuration.
   logic [15:0] free_room [NUM_BLOCKS];
   logic [1:0]  cfg_fit = fpba_pkg::FIT_FIRST;
   logic [4:0]  cfg_count = 5'd16;

   alloc_req_type pending_reqs [$];
   grant_type     expected_grants [$];

   int mismatch_count = 0;
   int gap_left = 0;
   bit idle_on = 1'b1;
   bit long_hold_ask = 1'b0;

   fit_policy_block_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_block_index     (req_block_index),
      .req_size_value      (req_size_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted         (rsp_granted),
      .rsp_chosen_block    (rsp_chosen_block),
      .rsp_remaining_after (rsp_remaining_after),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #4 clock = ~clock;

   // Apply one accepted request to the shadow table and queue its expected result.
   task automatic place_request(input alloc_req_type r);
      int        lim;
      int        pick;
      bit        found;
      grant_type res;
      if (r.kind == fpba_pkg::KIND_LOAD) begin
         free_room[r.blk] = r.amount;
      end else begin
         lim = (cfg_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(cfg_count);
         pick = 0;
         found = 1'b0;
         if (cfg_fit != fpba_pkg::FIT_NONE) begin
            for (int j = 0; j < lim; j++) begin
               if (free_room[j] >= r.amount) begin
                  if (!found) begin
                     pick = j;
                     found = 1'b1;
                     if (cfg_fit == fpba_pkg::FIT_FIRST) break;
                  end else if (cfg_fit == fpba_pkg::FIT_BEST &&
                               free_room[j] < free_room[pick]) begin
                     pick = j;
                  end else if (cfg_fit == fpba_pkg::FIT_WORST &&
                               free_room[j] > free_room[pick]) begin
                     pick = j;
                  end
               end
            end
         end
         if (found) begin
            free_room[pick] = free_room[pick] - r.amount;
            res = {1'b1, 4'(pick), free_room[pick]};
         end else begin
            res = '0;
         end
         expected_grants.push_back(res);
      end
   endtask

   task automatic push_item(input logic kind, input logic [3:0] blk, input logic [15:0] amount);
      alloc_req_type r;
      r = {kind, blk, amount};
      pending_reqs.push_back(r);
   endtask

   // Random mix of loads and allocation requests; sizes lean toward values that fit.
   task automatic queue_random(input int count);
      alloc_req_type r;
      int            pick;
      for (int n = 0; n < count; n++) begin
         r.blk = 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            r.kind = fpba_pkg::KIND_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 15) r.amount = 16'($urandom);
            else if (pick < 25) r.amount = 16'd4096;
            else if (pick < 40) r.amount = 16'($urandom_range(0, 100));
            else r.amount = 16'($urandom_range(1000, 9000));
         end else begin
            r.kind = fpba_pkg::KIND_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 10) r.amount = 16'd0;
            else if (pick < 20) r.amount = 16'($urandom);
            else r.amount = 16'($urandom_range(1, 1500));
         end
         pending_reqs.push_back(r);
      end
   endtask

   // Configuration writes happen only while the allocator is idle.
   task automatic write_csr(input logic [fpba_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [fpba_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == fpba_pkg::CSR_FIT_MODE) cfg_fit = data[1:0];
      else cfg_count = data;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Wait until every request is taken and every result is back, then let the scan settle.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_grants.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: offers queued items after a random gap and predicts each one taken.
   always @(posedge clock) begin
      alloc_req_type nxt;
      logic          held;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         held = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            place_request({req_kind, req_block_index, req_size_value});
            gap_left = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (!held) begin
            if (gap_left == 0 && pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_kind <= nxt.kind;
               req_block_index <= nxt.blk;
               req_size_value <= nxt.amount;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // Result monitor: compares each taken result and draws its own stall pattern.
   always @(posedge clock) begin
      grant_type got;
      grant_type want;
      int        stall_left;
      int        hold_left;
      bit        hold_started;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_started = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_granted, rsp_chosen_block, rsp_remaining_after};
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected result granted=%0d block=%0d remaining=%0d",
                        $time, got.granted, got.blk, got.remain);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected granted=%0d block=%0d remaining=%0d",
                           $time, want.granted, want.blk, want.remain);
                  $display("%0t:            actual granted=%0d block=%0d remaining=%0d",
                           $time, got.granted, got.blk, got.remain);
                  mismatch_count++;
               end
            end
            stall_left = idle_on ? $urandom_range(0, 4) : 0;
         end
         // One long hold so the allocator backs up and stalls its request side.
         if (long_hold_ask && !hold_started) begin
            hold_started = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any handshake or register write.
   always @(posedge clock) begin
      int stuck;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         stuck = 0;
      else
         stuck++;
      if (stuck >= STUCK_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Stimulus sequence: reset, directed items, then phases under changing settings.
   initial begin
      logic [1:0] fit;
      logic [4:0] cnt;
      int         pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Load every block first so no request ever reads an unwritten entry.
      push_item(fpba_pkg::KIND_LOAD, 4'd0, 16'd100);
      push_item(fpba_pkg::KIND_LOAD, 4'd1, 16'hFFFF);
      push_item(fpba_pkg::KIND_LOAD, 4'd2, 16'd0);
      push_item(fpba_pkg::KIND_LOAD, 4'd3, 16'd500);
      push_item(fpba_pkg::KIND_LOAD, 4'd4, 16'd50);
      push_item(fpba_pkg::KIND_LOAD, 4'd5, 16'hFFFF);
      push_item(fpba_pkg::KIND_LOAD, 4'd6, 16'd500);
      push_item(fpba_pkg::KIND_LOAD, 4'd7, 16'd7);
      push_item(fpba_pkg::KIND_LOAD, 4'd8, 16'd3000);
      push_item(fpba_pkg::KIND_LOAD, 4'd9, 16'd1);
      push_item(fpba_pkg::KIND_LOAD, 4'd10, 16'd4096);
      push_item(fpba_pkg::KIND_LOAD, 4'd11, 16'd4096);
      push_item(fpba_pkg::KIND_LOAD, 4'd12, 16'd20000);
      push_item(fpba_pkg::KIND_LOAD, 4'd13, 16'd9);
      push_item(fpba_pkg::KIND_LOAD, 4'd14, 16'd300);
      push_item(fpba_pkg::KIND_LOAD, 4'd15, 16'd12345);
      // Zero-size request, full-size requests until refused, index field ignored.
      push_item(fpba_pkg::KIND_ALLOC, 4'd0, 16'd0);
      push_item(fpba_pkg::KIND_ALLOC, 4'd15, 16'hFFFF);
      push_item(fpba_pkg::KIND_ALLOC, 4'd0, 16'hFFFF);
      push_item(fpba_pkg::KIND_ALLOC, 4'd7, 16'hFFFF);
      push_item(fpba_pkg::KIND_ALLOC, 4'd0, 16'd200);
      push_item(fpba_pkg::KIND_ALLOC, 4'd0, 16'd1);
      push_item(fpba_pkg::KIND_ALLOC, 4'hA, 16'd20000);
      push_item(fpba_pkg::KIND_LOAD, 4'd2, 16'hFFFF);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         // Fixed extremes first, then random settings.
         case (p)
            0: begin fit = fpba_pkg::FIT_BEST;  cnt = 5'd16; end
            1: begin fit = fpba_pkg::FIT_WORST; cnt = 5'd16; end
            2: begin fit = fpba_pkg::FIT_NONE;  cnt = 5'd16; end
            3: begin fit = fpba_pkg::FIT_FIRST; cnt = 5'd0;  end
            4: begin fit = fpba_pkg::FIT_BEST;  cnt = 5'd31; end
            5: begin fit = fpba_pkg::FIT_WORST; cnt = 5'd17; end
            6: begin fit = fpba_pkg::FIT_FIRST; cnt = 5'd1;  end
            7: begin fit = fpba_pkg::FIT_WORST; cnt = 5'd16; end
            default: begin
               pick = $urandom_range(0, 99);
               if (pick < 10) fit = fpba_pkg::FIT_NONE;
               else if (pick < 40) fit = fpba_pkg::FIT_FIRST;
               else if (pick < 70) fit = fpba_pkg::FIT_BEST;
               else fit = fpba_pkg::FIT_WORST;
               pick = $urandom_range(0, 99);
               if (pick < 5) cnt = 5'd0;
               else if (pick < 15) cnt = 5'($urandom_range(17, 31));
               else cnt = 5'($urandom_range(1, 16));
            end
         endcase
         write_csr(fpba_pkg::CSR_FIT_MODE, {3'b000, fit});
         write_csr(fpba_pkg::CSR_BLOCK_COUNT, cnt);
         idle_on = (p % 3 != 2);
         if (p == 1) long_hold_ask = 1'b1;
         queue_random(ITEMS_PER_PHASE);
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
